// ===== src/arfx_pkg.sv =====
// arfx_pkg: shared constants, opcodes and status codes for the register alu execute unit
// no dependencies
package arfx_pkg;

  localparam int REG_COUNT_DEF = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W = 5;

  localparam logic [4:0] OP_HALT = 5'd0;
  localparam logic [4:0] OP_ADD  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_MUL  = 5'd3;
  localparam logic [4:0] OP_DIV  = 5'd4;
  localparam logic [4:0] OP_AND  = 5'd5;
  localparam logic [4:0] OP_OR   = 5'd6;
  localparam logic [4:0] OP_XOR  = 5'd7;
  localparam logic [4:0] OP_SHL  = 5'd8;
  localparam logic [4:0] OP_SHR  = 5'd9;
  localparam logic [4:0] OP_SLT  = 5'd10;
  localparam logic [4:0] OP_SLE  = 5'd11;
  localparam logic [4:0] OP_SEQ  = 5'd12;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  dest_index;
    logic [DATA_W-1:0] write_value;
    logic              wrote;
    logic              halted;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/alu_register_file_execute_unit.sv =====
// alu_register_file_execute_unit: top level, sequencer with regfile memory and divider
// depends on arfx_pkg, arfx_regfile, arfx_divider
//
//  channel  dir  fields
//  s_axis   in   tdata[31:0] instruction
//  m_axis   out  tdata: dest_index[4:0] write_value[36:5] wrote[37] halted[38] status[40:39]
//
// an instruction goes through accept, regfile read, execute and write back, then the
// output register; a divide goes through the iterative divider before write back.
// after reset the register file is cleared one entry a cycle, while no instruction
// is accepted. a stalled output holds the next instruction off.
module alu_register_file_execute_unit import arfx_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // instruction[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // dest_index, write_value, wrote, halted, status, pad
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT} state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_idx;
  logic              halt_flag;
  logic [31:0]       ins;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  logic [DATA_W-1:0] a, b;
  logic [DATA_W-1:0] alu_res;
  logic [63:0]       prod;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  result_t           res;
  div_req_t          dreq;
  div_rsp_t          drsp;

  logic [4:0]  op;
  logic [4:0]  src, dst, bidx;
  logic        immf;
  logic [15:0] opnd;

  assign op   = ins[31:27];
  assign src  = ins[26:22];
  assign immf = ins[21];
  assign opnd = ins[20:5];
  assign dst  = ins[4:0];
  assign bidx = opnd[4:0];

  arfx_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk(clk), .raddr_a(src), .raddr_b(bidx), .rdata_a(rdata_a), .rdata_b(rdata_b),
    .we(we), .waddr(waddr), .wdata(wdata)
  );

  arfx_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign a = (32'(src) < 32'(REG_COUNT)) ? rdata_a : '0;
  assign b = immf ? {16'd0, opnd} : ((32'(bidx) < 32'(REG_COUNT)) ? rdata_b : '0);
  assign prod = 64'(a) * 64'(b);

  always_comb begin
    case (op)
      OP_ADD:  alu_res = a + b;
      OP_SUB:  alu_res = a - b;
      OP_MUL:  alu_res = prod[31:0];
      OP_AND:  alu_res = a & b;
      OP_OR:   alu_res = a | b;
      OP_XOR:  alu_res = a ^ b;
      OP_SHL:  alu_res = (b >= 32'd32) ? '0 : a << b[4:0];
      OP_SHR:  alu_res = (b >= 32'd32) ? '0 : a >> b[4:0];
      OP_SLT:  alu_res = {31'd0, a < b};
      OP_SLE:  alu_res = {31'd0, a <= b};
      default: alu_res = {31'd0, a == b};
    endcase
  end

  logic dst_ok;
  assign dst_ok = 32'(dst) < 32'(REG_COUNT);

  // apart from the clear after reset, only a supported operation before halt writes the register file
  logic exec_ok;
  assign exec_ok = !halt_flag && (op != OP_HALT) && (op <= OP_SEQ);

  always_comb begin
    we = 1'b0;
    waddr = dst;
    wdata = alu_res;
    dreq.start = 1'b0;
    dreq.dividend = a;
    dreq.divisor = b;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (state == S_EXEC && exec_ok) begin
      if (op != OP_DIV) begin
        we = dst_ok;
      end else if (b != '0) begin
        dreq.start = 1'b1;
      end else begin
        we = dst_ok;
        wdata = '1;
      end
    end else if (state == S_DIV && drsp.done) begin
      we = dst_ok;
      wdata = drsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      halt_flag <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 5'd1;
          if (32'(clr_idx) == 32'(REG_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ins <= s_axis_tdata;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          res.dest_index <= '0;
          res.write_value <= '0;
          res.wrote <= 1'b0;
          res.halted <= halt_flag;
          res.status <= ST_OK;
          state <= S_OUT;
          m_axis_tvalid <= 1'b1;
          if (halt_flag) begin
            res.status <= ST_IGNORED;
          end else if (op == OP_HALT) begin
            halt_flag <= 1'b1;
            res.halted <= 1'b1;
          end else if (op > OP_SEQ) begin
            res.status <= ST_UNSUP;
          end else if (op == OP_DIV && b != '0) begin
            state <= S_DIV;
            m_axis_tvalid <= 1'b0;
          end else begin
            if (op == OP_DIV) res.status <= ST_DIVZERO;
            if (dst_ok) begin
              res.dest_index <= dst;
              res.write_value <= wdata;
              res.wrote <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (dst_ok) begin
              res.dest_index <= dst;
              res.write_value <= drsp.quotient;
              res.wrote <= 1'b1;
            end
            m_axis_tvalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata = {7'd0, res.status, res.halted, res.wrote, res.write_value,
                         res.dest_index};

endmodule

// ===== src/arfx_divider.sv =====
// arfx_divider: radix-2 restoring divider, one quotient bit per cycle
// depends on arfx_pkg
module arfx_divider import arfx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [5:0]        cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   trial;

  assign trial = {rem, quo[DATA_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= 6'(DATA_W);
      end else if (busy) begin
        if (trial[DATA_W]) begin
          rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
          quo <= {quo[DATA_W-2:0], 1'b0};
        end else begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};

endmodule

// ===== src/arfx_regfile.sv =====
// arfx_regfile: register file memory, two registered read ports, one write port
// depends on arfx_pkg
module arfx_regfile import arfx_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  raddr_a,
  input  logic [IDX_W-1:0]  raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [REG_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/arfx_checker.sv =====
// arfx_assert: port-level assertions for the execute unit, bound to the top level
// depends on alu_register_file_execute_unit
module arfx_assert (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic halt_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_seen <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[38]) begin
      halt_seen <= 1'b1;
    end
  end

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && halt_seen |-> m_axis_tdata[38]) else $error("halt flag cleared");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[37] |-> m_axis_tdata[36:0] == 37'd0)
    else $error("payload without write");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:41] == 7'd0) else $error("pad bits set");

endmodule

bind alu_register_file_execute_unit arfx_assert u_arfx_assert (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
